### design/lkc_pkg.sv
`default_nettype none

package lkc_pkg;

  localparam int ENTRIES_DEF      = 16;
  localparam int KEY_BITS_DEF     = 32;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam int FIELD_W = 32;
  localparam int MODE_W  = 2;
  localparam int CAP_W   = 5;
  localparam int OCC_W   = 5;

  localparam logic [MODE_W-1:0] MODE_GET   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;
  localparam int CFG_IDXW = CFG_AW - 2;
  localparam logic [CFG_IDXW-1:0] REG_CAPACITY = 1'd0;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [FIELD_W-1:0] lookup_key;
    logic [FIELD_W-1:0] program_in;
    logic [FIELD_W-1:0] response_in;
  } lkc_in_t;

  typedef struct packed {
    logic               hit;
    logic [FIELD_W-1:0] program_out;
    logic [FIELD_W-1:0] response_out;
    logic               evicted;
    logic [OCC_W-1:0]   occupancy;
  } lkc_out_t;

  typedef struct packed {
    logic hit;
    logic evicted;
    logic pay_wr;
    logic pay_rd;
  } lkc_tag_res_t;

endpackage

`default_nettype wire

### design/lru_keyed_cache_unit.sv
`default_nettype none
// channel  | ports                          | beat
// in       | in_valid, in_ready, in_data    | one op: get, put or clear
// out      | out_valid, out_ready, out_data | one result per op
// cfg      | cfg_p*  (apb, 3-bit address)   | capacity limit at 0x0
//
// each op runs exec (parallel key compare, rank update, payload ram
// access) then fill (registered ram read); the next op enters with fill
// synchronous reset empties the tag array at once; no clearing pass
// a result not taken holds in the output register and stalls in fill

module lru_keyed_cache_unit
  import lkc_pkg::*;
#(
  parameter int ENTRIES      = ENTRIES_DEF,
  parameter int KEY_BITS     = KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire lkc_in_t           in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output lkc_out_t               out_data,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int PW = 2 * PAYLOAD_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FILL
  } state_t;

  state_t       state_r, state_nxt;
  lkc_in_t      op_r;
  lkc_out_t     out_r, out_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic         hit_r, evicted_r, rd_r;
  logic [CAP_W-1:0] cap_r;

  lkc_tag_res_t tres;
  logic [SW-1:0] slot;
  logic [CW-1:0] count;
  logic [PW-1:0] rdata;
  logic          exec, out_load, accept, cfg_wr;

  assign exec     = (state_r == ST_EXEC);
  assign out_load = (state_r == ST_FILL) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == ST_IDLE) || out_load;
  assign accept   = in_valid && in_ready;

  lkc_tag_array #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_tags (
    .clk   (clk),
    .rst_n (rst_n),
    .exec  (exec),
    .mode  (op_r.mode),
    .key   (KEY_BITS'(op_r.lookup_key)),
    .cap   (cap_r),
    .res   (tres),
    .slot  (slot),
    .count (count)
  );

  lkc_payload_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (PW)
  ) u_payload (
    .clk   (clk),
    .addr  (slot),
    .we    (exec && tres.pay_wr),
    .wdata ({PAYLOAD_BITS'(op_r.program_in), PAYLOAD_BITS'(op_r.response_in)}),
    .re    (exec && tres.pay_rd),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_FILL;
      ST_FILL: begin
        if (out_load) state_nxt = accept ? ST_EXEC : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_nxt              = out_r;
    out_nxt.hit          = hit_r;
    out_nxt.evicted      = evicted_r;
    out_nxt.occupancy    = OCC_W'(count);
    out_nxt.program_out  = rd_r ? FIELD_W'(rdata[PW-1:PAYLOAD_BITS]) : '0;
    out_nxt.response_out = rd_r ? FIELD_W'(rdata[PAYLOAD_BITS-1:0]) : '0;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (accept) begin
      op_r <= in_data;
    end
    if (exec) begin
      hit_r     <= tres.hit;
      evicted_r <= tres.evicted;
      rd_r      <= tres.pay_rd;
    end
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // register block
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite
               && (cfg_paddr[CFG_AW-1:2] == REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr) begin
      cap_r <= cfg_pwdata[CAP_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[CFG_AW-1:2] == REG_CAPACITY) ? CFG_DW'(cap_r) : '0;
  assign cfg_pready = 1'b1;

endmodule

`default_nettype wire

### design/lkc_payload_ram.sv
`default_nettype none

module lkc_payload_ram
  import lkc_pkg::*;
#(
  parameter int DEPTH = ENTRIES_DEF,
  parameter int WIDTH = 2 * PAYLOAD_BITS_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic [AW-1:0]    addr,
  input  wire logic             we,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### design/lkc_tag_array.sv
`default_nettype none

module lkc_tag_array
  import lkc_pkg::*;
#(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF,
  localparam int SW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int CW      = $clog2(ENTRIES + 1),
  localparam int CMPW    = ((CW > CAP_W) ? CW : CAP_W) + 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                exec,
  input  wire logic [MODE_W-1:0]   mode,
  input  wire logic [KEY_BITS-1:0] key,
  input  wire logic [CAP_W-1:0]    cap,
  output lkc_tag_res_t             res,
  output logic      [SW-1:0]       slot,
  output logic      [CW-1:0]       count
);

  logic [KEY_BITS-1:0] key_r [ENTRIES];
  logic [SW-1:0]       rank_r [ENTRIES];
  logic [SW-1:0]       rank_nxt [ENTRIES];
  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic [CW-1:0]       count_r, count_nxt;

  logic [ENTRIES-1:0]  match, victim, valid_ev;
  logic                found, need_evict, is_get, is_put, put_miss;
  logic [SW-1:0]       hit_slot, free_slot, hit_rank, lru_rank;
  logic [CMPW-1:0]     cap_eff, cnt_plus;

  assign is_get   = (mode == MODE_GET);
  assign is_put   = (mode == MODE_PUT);
  assign put_miss = is_put && !found;
  assign lru_rank = SW'(count_r - CW'(1));

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid_r[i] && (key_r[i] == key);
      victim[i] = valid_r[i] && (rank_r[i] == lru_rank);
    end
  end

  assign found = |match;

  always_comb begin
    hit_slot = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_slot = SW'(i);
      end
    end
  end

  assign hit_rank = rank_r[hit_slot];

  // clamp the limit into one..entries
  always_comb begin
    cap_eff = CMPW'(cap);
    if (cap == '0) begin
      cap_eff = CMPW'(1);
    end else if (CMPW'(cap) > CMPW'(ENTRIES)) begin
      cap_eff = CMPW'(ENTRIES);
    end
  end

  assign cnt_plus   = CMPW'(count_r) + CMPW'(1);
  assign need_evict = put_miss && (cnt_plus > cap_eff) && (count_r != '0);
  assign valid_ev   = need_evict ? (valid_r & ~victim) : valid_r;

  always_comb begin
    free_slot = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_ev[i]) begin
        free_slot = SW'(i);
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    unique case (mode)
      MODE_GET, MODE_PUT: begin
        if (found) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_r[i] && (rank_r[i] < hit_rank)) begin
              rank_nxt[i] = rank_r[i] + SW'(1);
            end
          end
          rank_nxt[hit_slot] = '0;
        end else if (is_put) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_ev[i]) begin
              rank_nxt[i] = rank_r[i] + SW'(1);
            end else if (need_evict && victim[i]) begin
              rank_nxt[i] = '0;
            end
          end
          valid_nxt            = valid_ev;
          valid_nxt[free_slot] = 1'b1;
          rank_nxt[free_slot]  = '0;
          count_nxt = count_r + CW'(1) - (need_evict ? CW'(1) : CW'(0));
        end
      end
      MODE_CLEAR: begin
        valid_nxt = '0;
        count_nxt = '0;
        for (int i = 0; i < ENTRIES; i++) begin
          rank_nxt[i] = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else if (exec) begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec && put_miss) begin
      key_r[free_slot] <= key;
    end
  end

  assign res.hit     = found && (is_get || is_put);
  assign res.evicted = need_evict;
  assign res.pay_wr  = is_put;
  assign res.pay_rd  = is_get && found;
  assign slot        = found ? hit_slot : free_slot;
  assign count       = count_r;

  a_count_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CW'($countones(valid_r)))
    else $error("entry count out of step with valid bits");

  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("key present in more than one entry");

  a_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
    exec && put_miss |-> !valid_ev[free_slot])
    else $error("insert into a live entry");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    exec && (mode == MODE_CLEAR) |=> (count_r == '0) && (valid_r == '0))
    else $error("clear left entries behind");

endmodule

`default_nettype wire
